// File: sv/assert_macros.svh
// Assertion macros shared by the histogram median RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: sv/hmed_pkg.sv
// Types and constants of the histogram median block.
// No dependencies; used by hmed_ctrl, hmed_dp and histogram_median_8bit.
package hmed_pkg;

   localparam int PixWidth   = 8;
   localparam int CountWidth = 20;
   localparam int Bins       = 256;

   typedef logic [PixWidth-1:0]   pix_type;
   typedef logic [CountWidth-1:0] count_type;

   // Pixels beyond this count in one frame are dropped
   localparam count_type MaxPixels = count_type'(524288);

   // Controller to datapath
   typedef struct packed {
      logic accept;   // pixel transfer this cycle
      logic scan;     // read bins in order for the median search
      logic clear;    // end of frame: clear histogram and counters
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic found;    // median bin has been located
   } status_type;

endpackage

// File: sv/hmed_ctrl.sv
// Controller of the histogram median block: frame sequencing and handshake.
// Depends on hmed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hmed_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last,
   input  hmed_pkg::status_type st,
   output logic               busy,
   output logic               rsp_valid,
   output hmed_pkg::cmd_type  cmd
);
   import hmed_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = start & ~busy_ff;

   // Commands are decoded combinationally from the state and the start handshake
   always_comb begin
      cmd.accept = accept;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.clear  = (state_ff == ST_EMIT);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_RUN: begin
               if (accept && req_last) begin
                  state_ff <= ST_DRAIN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_DRAIN: begin
               // last pixel's bin update lands this cycle
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (st.found) begin
                  state_ff     <= ST_EMIT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               state_ff     <= ST_RUN;
               rsp_valid_ff <= 1'b0;
               busy_ff      <= 1'b0;
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_last_sets_busy, clock, reset, accept && req_last, busy_ff)
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_IMPL(a_strobe_after_found, clock, reset, rsp_valid_ff, $past(st.found))

endmodule

// File: sv/hmed_dp.sv
// Datapath of the histogram median block: bin RAM with read-modify-write,
// pixel counter and cumulative scan. Depends on hmed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hmed_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  hmed_pkg::pix_type    req_pixel,
   input  hmed_pkg::cmd_type    cmd,
   output hmed_pkg::status_type st,
   output hmed_pkg::pix_type    rsp_median,
   output hmed_pkg::count_type  rsp_pixel_count
);
   import hmed_pkg::*;

   // Bin storage; entries with a clear valid bit read as zero
   count_type       hist_mem [Bins];
   logic [Bins-1:0] bin_vld_ff;

   count_type cnt_ff;
   count_type rd_ff;
   logic      rd_vld_ff;
   pix_type   rd_addr;

   // Update stage
   logic      upd_en_ff;
   pix_type   upd_pix_ff;
   logic      hit_ff;
   count_type wr_last_ff;
   count_type bin_val;
   count_type upd_sum;
   logic      count_en;

   // Scan stage
   pix_type   scan_addr_ff;
   pix_type   scan_idx_ff;
   logic      scan_vld_ff;
   count_type run_ff;
   count_type run_sum;
   count_type half;
   logic      found_ff;
   pix_type   median_ff;

   assign count_en = cmd.accept && (cnt_ff < MaxPixels);
   assign rd_addr  = cmd.scan ? scan_addr_ff : req_pixel;
   assign bin_val  = rd_vld_ff ? rd_ff : '0;
   // back-to-back hit on the same bin takes the value being written
   assign upd_sum  = (hit_ff ? wr_last_ff : bin_val) + count_type'(1);
   assign half     = cnt_ff >> 1;
   assign run_sum  = run_ff + bin_val;

   // RAM port and update payload
   always_ff @(posedge clock) begin
      rd_ff      <= hist_mem[rd_addr];
      upd_pix_ff <= req_pixel;
      hit_ff     <= upd_en_ff && (upd_pix_ff == req_pixel);
      if (upd_en_ff) begin
         hist_mem[upd_pix_ff] <= upd_sum;
         wr_last_ff           <= upd_sum;
      end
      scan_idx_ff <= scan_addr_ff;
   end

   // Valid bits, counters and scan control
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         bin_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         cnt_ff       <= '0;
         upd_en_ff    <= 1'b0;
         scan_addr_ff <= '0;
         scan_vld_ff  <= 1'b0;
         run_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         rd_vld_ff   <= bin_vld_ff[rd_addr];
         upd_en_ff   <= count_en;
         scan_vld_ff <= cmd.scan;
         if (upd_en_ff) begin
            bin_vld_ff[upd_pix_ff] <= 1'b1;
         end
         if (count_en) begin
            cnt_ff <= cnt_ff + count_type'(1);
         end
         if (cmd.scan) begin
            scan_addr_ff <= scan_addr_ff + pix_type'(1);
         end
         if (scan_vld_ff) begin
            run_ff <= run_sum;
            if (!found_ff && (run_sum > half)) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // Median bin capture
   always_ff @(posedge clock) begin
      if (scan_vld_ff && !found_ff && (run_sum > half)) begin
         median_ff <= scan_idx_ff;
      end
   end

   assign st.found        = found_ff;
   assign rsp_median      = median_ff;
   assign rsp_pixel_count = cnt_ff;

   `ASSERT_IMPL(a_count_saturates, clock, reset, 1'b1, cnt_ff <= MaxPixels)
   `ASSERT_IMPL(a_found_past_half, clock, reset, found_ff, run_ff > half)
   `ASSERT_IMPL(a_scan_read_issued, clock, reset, scan_vld_ff, $past(cmd.scan))

endmodule

// File: sv/histogram_median_8bit.sv
// Top level of the 8-bit histogram median block.
// Depends on hmed_pkg, hmed_ctrl and hmed_dp.
//
//   channel   ports                                 handshake
//   input     req_pixel, req_last                   start high, busy low
//   result    rsp_median, rsp_pixel_count           rsp_valid, one cycle
//
// One pixel transfer per clock while busy is low; a pixel without the last
// flag produces no result. After the last pixel busy stays high through the
// DRAIN state for the final bin update, then the scan, which reads one bin per
// cycle from gray level 0 through the single histogram RAM read port until
// the median bin is flagged, then the EMIT state with rsp_valid high. Valid
// bits clear all at once on reset and at the end of each frame, so no clearing
// pass follows reset. The receiver cannot stall.
module histogram_median_8bit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  hmed_pkg::pix_type   req_pixel,
   input  logic                req_last,
   output logic                rsp_valid,
   output hmed_pkg::pix_type   rsp_median,
   output hmed_pkg::count_type rsp_pixel_count
);
   import hmed_pkg::*;

   cmd_type    cmd;
   status_type st;

   hmed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .st        (st),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   hmed_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_pixel       (req_pixel),
      .cmd             (cmd),
      .st              (st),
      .rsp_median      (rsp_median),
      .rsp_pixel_count (rsp_pixel_count)
   );

endmodule
